/* rtl/srlm_pkg.sv */
// ----------------------------------------------------------------------------
// srlm_pkg
// Shared widths and constants of the stereo RMS level meter.
// ----------------------------------------------------------------------------
package srlm_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

    localparam int SMP_W   = 16;
    localparam int SQ_W    = 29;          // floor(s*s/4) <= 2^28
    localparam int SUM_W   = 38;
    localparam int QUO_W   = SUM_W + 1;   // 2*sum / count
    localparam int RAD_W   = 32;          // mean square never exceeds 2^30
    localparam int ROOT_W  = 16;
    localparam int ACC_W   = 24;
    localparam int LVL_W   = 16;

    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int WOLD_W = 16;
    localparam int WNEW_W = 13;
    localparam logic [WOLD_W-1:0] W_OLD = 16'd60948;
    localparam logic [WNEW_W-1:0] W_NEW = 13'd4588;

    localparam int POLD_W = ACC_W + WOLD_W;
    localparam int PNEW_W = ROOT_W + WNEW_W;
    localparam int MIX_W  = POLD_W + 1;

    localparam logic [MIX_W-1:0] MIX_HALF = MIX_W'(32768);
    localparam logic [ACC_W:0]   ACC_HALF = (ACC_W + 1)'(128);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAMES);

endpackage

/* rtl/srlm_lane.sv */
// ----------------------------------------------------------------------------
// srlm_lane
// One channel lane: squares the halved sample, registered.
// ----------------------------------------------------------------------------
module srlm_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic signed [srlm_pkg::SMP_W-1:0] i_sample,
    output logic [srlm_pkg::SQ_W-1:0]        o_sq
);

    logic signed [2*srlm_pkg::SMP_W-1:0] prod;
    logic [srlm_pkg::SQ_W-1:0]           r_sq;
    logic [srlm_pkg::SQ_W-1:0]           n_sq;

    assign prod = i_sample * i_sample;

    // square is non-negative and at most 2^30; drop two LSBs for the halving
    assign n_sq = i_en ? prod[srlm_pkg::SQ_W+1:2] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= '0;
        end else begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

/* rtl/srlm_merge.sv */
// ----------------------------------------------------------------------------
// srlm_merge
// Combines the two lane squares into the saturating block sum.
// ----------------------------------------------------------------------------
module srlm_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic [srlm_pkg::SQ_W-1:0]   i_sq_l,
    input  logic [srlm_pkg::SQ_W-1:0]   i_sq_r,
    output logic [srlm_pkg::SUM_W-1:0]  o_sum
);

    logic [srlm_pkg::SQ_W:0]    pair;
    logic [srlm_pkg::SUM_W:0]   total;
    logic [srlm_pkg::SUM_W-1:0] r_sum;
    logic [srlm_pkg::SUM_W-1:0] n_sum;

    assign pair  = {1'b0, i_sq_l} + {1'b0, i_sq_r};
    assign total = {1'b0, r_sum} + (srlm_pkg::SUM_W + 1)'(pair);

    always_comb begin
        if (i_clear) begin
            n_sum = '0;
        end else if (total[srlm_pkg::SUM_W]) begin
            n_sum = '1;
        end else begin
            n_sum = total[srlm_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

/* rtl/srlm_divsqrt.sv */
// ----------------------------------------------------------------------------
// srlm_divsqrt
// Mean square and root: restoring divide of 2*sum by the frame count,
// one quotient bit per cycle, then a bit-pair-per-cycle integer square root.
// ----------------------------------------------------------------------------
module srlm_divsqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [srlm_pkg::SUM_W-1:0]   i_sum,
    input  logic [srlm_pkg::CNT_W-1:0]   i_count,
    output logic                         o_done,
    output logic [srlm_pkg::ROOT_W-1:0]  o_root
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_SQRT = 3'b100
    } t_ds_state;

    t_ds_state                      r_state, n_state;
    logic [srlm_pkg::STEP_W-1:0]    r_step, n_step;
    logic                           r_done, n_done;

    logic [srlm_pkg::QUO_W-1:0]     r_quo, n_quo;
    logic [srlm_pkg::CNT_W-1:0]     r_rem, n_rem;
    logic [srlm_pkg::CNT_W-1:0]     r_div, n_div;
    logic [srlm_pkg::RAD_W-1:0]     r_rad, n_rad;
    logic [srlm_pkg::ROOT_W+1:0]    r_srem, n_srem;
    logic [srlm_pkg::ROOT_W-1:0]    r_root, n_root;

    logic [srlm_pkg::CNT_W:0]       drem_sh;
    logic                           dge;
    logic [srlm_pkg::CNT_W:0]       drem_sub;
    logic [srlm_pkg::QUO_W-1:0]     quo_step;
    logic [srlm_pkg::ROOT_W+3:0]    srem_sh;
    logic [srlm_pkg::ROOT_W+3:0]    trial;
    logic [srlm_pkg::ROOT_W+3:0]    srem_sub;
    logic                           sge;

    assign drem_sh  = {r_rem, r_quo[srlm_pkg::QUO_W-1]};
    assign dge      = drem_sh >= {1'b0, r_div};
    assign drem_sub = drem_sh - {1'b0, r_div};
    assign quo_step = {r_quo[srlm_pkg::QUO_W-2:0], dge};

    assign srem_sh  = {r_srem, r_rad[srlm_pkg::RAD_W-1 -: 2]};
    assign trial    = (srlm_pkg::ROOT_W + 4)'({r_root, 2'b01});
    assign sge      = srem_sh >= trial;
    assign srem_sub = srem_sh - trial;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_done  = 1'b0;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_rad   = r_rad;
        n_srem  = r_srem;
        n_root  = r_root;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_quo   = {i_sum, 1'b0};
                    n_rem   = '0;
                    n_div   = i_count;
                    n_step  = srlm_pkg::STEP_W'(srlm_pkg::DIV_STEPS - 1);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_quo = quo_step;
                n_rem = dge ? drem_sub[srlm_pkg::CNT_W-1:0]
                            : drem_sh[srlm_pkg::CNT_W-1:0];
                if (r_step == '0) begin
                    n_rad   = quo_step[srlm_pkg::RAD_W-1:0];
                    n_srem  = '0;
                    n_root  = '0;
                    n_step  = srlm_pkg::STEP_W'(srlm_pkg::SQRT_STEPS - 1);
                    n_state = ST_SQRT;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_SQRT: begin
                n_rad  = {r_rad[srlm_pkg::RAD_W-3:0], 2'b00};
                n_srem = sge ? srem_sub[srlm_pkg::ROOT_W+1:0]
                             : srem_sh[srlm_pkg::ROOT_W+1:0];
                n_root = {r_root[srlm_pkg::ROOT_W-2:0], sge};
                if (r_step == '0) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_rad  <= n_rad;
        r_srem <= n_srem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* rtl/stereo_rms_level_meter_core.sv */
// ----------------------------------------------------------------------------
// stereo_rms_level_meter_core
// Block RMS and exponentially smoothed level of a stream of stereo left/right frames.
// ----------------------------------------------------------------------------
// Frames that do not close a block are taken one per cycle: two lanes square
// the halved left and right samples and a merge stage adds both into a
// saturating sum. The frame marked last stops intake while the mean square is
// formed and rooted: the lane and merge registers settle the sum, the
// bit-serial divider and the square root run, and the hand-off and smoothing
// states follow before the result is offered, later if the previous result has
// not yet been taken. A pending result does not stop intake of the next block.
// Frames beyond MAX_FRAMES in a block are dropped and flagged as overrun.
// ----------------------------------------------------------------------------
module stereo_rms_level_meter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [srlm_pkg::SMP_W-1:0] i_left_sample,
    input  logic signed [srlm_pkg::SMP_W-1:0] i_right_sample,
    input  logic                              i_last_frame,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [srlm_pkg::ROOT_W-1:0]       o_block_rms,
    output logic [srlm_pkg::LVL_W-1:0]        o_smoothed_level,
    output logic                              o_overrun
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SETTLE = 7'b0000010,
        ST_START  = 7'b0000100,
        ST_WAIT   = 7'b0001000,
        ST_MUL    = 7'b0010000,
        ST_UPD    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [srlm_pkg::CNT_W-1:0]      r_count, n_count;
    logic                            r_ovr, n_ovr;
    logic [srlm_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [srlm_pkg::POLD_W-1:0]     r_pold;
    logic [srlm_pkg::PNEW_W-1:0]     r_pnew;
    logic [srlm_pkg::ROOT_W-1:0]     r_rms;
    logic                            r_ovalid, n_ovalid;
    logic [srlm_pkg::ROOT_W-1:0]     r_orms;
    logic [srlm_pkg::LVL_W-1:0]      r_olvl;
    logic                            r_oovr;

    logic                            accept;
    logic                            keep;
    logic                            load_out;
    logic                            clear_sum;
    logic [srlm_pkg::SQ_W-1:0]       sq_l, sq_r;
    logic [srlm_pkg::SUM_W-1:0]      sum;
    logic                            ds_done;
    logic [srlm_pkg::ROOT_W-1:0]     ds_root;
    logic [srlm_pkg::MIX_W-1:0]      mix;
    logic [srlm_pkg::ACC_W:0]        acc_rnd;
    logic [srlm_pkg::LVL_W-1:0]      level;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign keep     = (r_count < srlm_pkg::CNT_MAX);
    assign load_out = (r_state == ST_OUT) && (!r_ovalid || i_ready);
    assign clear_sum = load_out;

    srlm_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept && keep),
        .i_sample (i_left_sample),
        .o_sq     (sq_l)
    );

    srlm_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept && keep),
        .i_sample (i_right_sample),
        .o_sq     (sq_r)
    );

    srlm_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (clear_sum),
        .i_sq_l   (sq_l),
        .i_sq_r   (sq_r),
        .o_sum    (sum)
    );

    srlm_divsqrt u_divsqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == ST_START),
        .i_sum    (sum),
        .i_count  (r_count),
        .o_done   (ds_done),
        .o_root   (ds_root)
    );

    // acc*W_OLD + (rms<<8)*W_NEW, rounded half up, keep Q0.24
    assign mix = {1'b0, r_pold}
               + srlm_pkg::MIX_W'({r_pnew, 8'h00})
               + srlm_pkg::MIX_HALF;

    assign acc_rnd = {1'b0, r_acc} + srlm_pkg::ACC_HALF;
    assign level   = acc_rnd[srlm_pkg::ACC_W] ? '1
                                              : acc_rnd[srlm_pkg::ACC_W-1:8];

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovr    = r_ovr;
        n_acc    = r_acc;
        n_ovalid = r_ovalid;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (keep) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovr = 1'b1;
                    end
                    if (i_last_frame) begin
                        n_state = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE: begin
                n_state = ST_START;
            end
            ST_START: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (ds_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_acc   = mix[srlm_pkg::ACC_W+15:16];
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (load_out) begin
                    n_ovalid = 1'b1;
                    n_count  = '0;
                    n_ovr    = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovr    <= 1'b0;
            r_acc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovr    <= n_ovr;
            r_acc    <= n_acc;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WAIT) begin
            r_rms  <= ds_root;
            r_pold <= r_acc * srlm_pkg::W_OLD;
            r_pnew <= ds_root * srlm_pkg::W_NEW;
        end
        if (load_out) begin
            r_orms <= r_rms;
            r_olvl <= level;
            r_oovr <= r_ovr;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_block_rms      = r_orms;
    assign o_smoothed_level = r_olvl;
    assign o_overrun        = r_oovr;

endmodule

/* rtl/srlm_checker.sv */
// ----------------------------------------------------------------------------
// srlm_checker
// Port-level checks of the stereo RMS level meter, bound to the top level.
// ----------------------------------------------------------------------------
module srlm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic signed [srlm_pkg::SMP_W-1:0] i_left_sample,
    input logic signed [srlm_pkg::SMP_W-1:0] i_right_sample,
    input logic                              i_last_frame,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [srlm_pkg::ROOT_W-1:0]       o_block_rms,
    input logic [srlm_pkg::LVL_W-1:0]        o_smoothed_level,
    input logic                              o_overrun
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_block_rms) && $stable(o_smoothed_level)
            && $stable(o_overrun))
        else $error("result changed while stalled");

    // halved full-scale samples give an RMS of at most one half
    a_rms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_block_rms <= 16'd32768)
        else $error("block RMS out of range");

    // a new result only follows a closing computation, during which intake stops
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result appeared without a closing frame");

    // a closing frame stops intake on the next cycle
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last_frame |=> !o_ready)
        else $error("intake continued after closing frame");

endmodule

bind stereo_rms_level_meter_core srlm_checker u_srlm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .i_left_sample    (i_left_sample),
    .i_right_sample   (i_right_sample),
    .i_last_frame     (i_last_frame),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_block_rms      (o_block_rms),
    .o_smoothed_level (o_smoothed_level),
    .o_overrun        (o_overrun)
);
